FILE: src/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH_DEF = 16;
    localparam int STAMP_WIDTH    = 32;

    // widths of the result fields at the ports
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_PRIO_W  = 16;
    localparam int OUT_COUNT_W = 7;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_LAST,
        ST_DOWN,
        ST_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    idle;
        logic    done;
        status_t status;
    } eng_stat_t;

endpackage

FILE: src/spq_ram.sv
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: src/spq_engine.sv
module spq_engine #(
    parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             func,
    input  logic [DATA_WIDTH-1:0]            new_data,
    input  logic [PRIO_WIDTH-1:0]            new_prio,
    input  logic                             res_take,
    output spq_pkg::eng_stat_t               stat,
    output logic [DATA_WIDTH-1:0]            pop_data,
    output logic [PRIO_WIDTH-1:0]            pop_prio,
    output logic [DATA_WIDTH-1:0]            head_data,
    output logic [PRIO_WIDTH-1:0]            head_prio,
    output logic [$clog2(CAPACITY+1)-1:0]    count
);

    localparam int SW = spq_pkg::STAMP_WIDTH;
    localparam int EW = DATA_WIDTH + PRIO_WIDTH + SW;
    localparam int KW = PRIO_WIDTH + SW;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam logic [PRIO_WIDTH-1:0] PSIGN = PRIO_WIDTH'(1) << (PRIO_WIDTH - 1);

    // entry layout: {data, priority, stamp}
    function automatic logic above(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [KW-1:0] ka;
        logic [KW-1:0] kb;
        ka = {a[KW-1:SW] ^ PSIGN, ~a[SW-1:0]};
        kb = {b[KW-1:SW] ^ PSIGN, ~b[SW-1:0]};
        return ka > kb;
    endfunction

    spq_pkg::state_t  state_reg, state_next;
    spq_pkg::status_t status_reg, status_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         stamp_reg, stamp_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [EW-1:0]         x_reg, x_next;
    logic [EW-1:0]         head_reg;
    logic [DATA_WIDTH-1:0] pop_data_reg, pop_data_next;
    logic [PRIO_WIDTH-1:0] pop_prio_reg, pop_prio_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [AW-1:0] ra_a;
    logic [AW-1:0] ra_b;
    logic [EW-1:0] rd_a;
    logic [EW-1:0] rd_b;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (ra_a),
        .rdata_a (rd_a),
        .raddr_b (ra_b),
        .rdata_b (rd_b)
    );

    logic          is_full;
    logic          is_zero;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_par;
    logic [EW-1:0] new_entry;
    logic [AW-1:0] idx_m1;
    logic [AW-1:0] par;
    logic [AW-1:0] par_m1;
    logic [AW-1:0] gpar;
    logic [IW-1:0] n_w;
    logic [IW-1:0] l_w;
    logic [IW-1:0] r_w;
    logic          l_valid;
    logic          r_valid;
    logic          x_above_p;
    logic          l_gt_x;
    logic          r_gt_x;
    logic          r_gt_l;
    logic          pick_l;
    logic          pick_r;
    logic [AW-1:0] child;
    logic [IW-1:0] cl_w;
    logic [IW-1:0] cr_w;
    logic          cl_valid;

    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_zero   = (count_reg == '0);
    assign cnt_m1    = count_reg - 1'b1;
    assign cnt_par   = cnt_m1 >> 1;
    assign new_entry = {new_data, new_prio, stamp_reg};

    assign idx_m1 = idx_reg - 1'b1;
    assign par    = idx_m1 >> 1;
    assign par_m1 = par - 1'b1;
    assign gpar   = par_m1 >> 1;

    assign n_w     = {{(IW-CW){1'b0}}, count_reg};
    assign l_w     = ({2'b00, idx_reg} << 1) | IW'(1);
    assign r_w     = l_w + 1'b1;
    assign l_valid = (l_w < n_w);
    assign r_valid = (r_w < n_w);

    assign x_above_p = above(x_reg, rd_a);
    assign l_gt_x    = l_valid && above(rd_a, x_reg);
    assign r_gt_x    = above(rd_b, x_reg);
    assign r_gt_l    = above(rd_b, rd_a);
    assign pick_r    = r_valid && (l_gt_x ? r_gt_l : r_gt_x);
    assign pick_l    = l_gt_x && !pick_r;
    assign child     = pick_r ? r_w[AW-1:0] : l_w[AW-1:0];
    assign cl_w      = ({2'b00, child} << 1) | IW'(1);
    assign cr_w      = cl_w + 1'b1;
    assign cl_valid  = (cl_w < n_w);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!func)
                    begin
                        state_next = (is_full || is_zero) ? spq_pkg::ST_DONE : spq_pkg::ST_UP;
                    end
                    else
                    begin
                        state_next = (is_zero || count_reg == CW'(1)) ?
                                     spq_pkg::ST_DONE : spq_pkg::ST_LAST;
                    end
                end
            end
            spq_pkg::ST_UP:
            begin
                if (x_above_p)
                begin
                    state_next = (par == '0) ? spq_pkg::ST_WB : spq_pkg::ST_UP;
                end
                else
                begin
                    state_next = spq_pkg::ST_DONE;
                end
            end
            spq_pkg::ST_LAST:
            begin
                state_next = l_valid ? spq_pkg::ST_DOWN : spq_pkg::ST_DONE;
            end
            spq_pkg::ST_DOWN:
            begin
                if (pick_l || pick_r)
                begin
                    state_next = cl_valid ? spq_pkg::ST_DOWN : spq_pkg::ST_WB;
                end
                else
                begin
                    state_next = spq_pkg::ST_DONE;
                end
            end
            spq_pkg::ST_WB:
            begin
                state_next = spq_pkg::ST_DONE;
            end
            spq_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        we            = 1'b0;
        waddr         = idx_reg;
        wdata         = x_reg;
        ra_a          = l_w[AW-1:0];
        ra_b          = r_w[AW-1:0];
        status_next   = status_reg;
        count_next    = count_reg;
        stamp_next    = stamp_reg;
        idx_next      = idx_reg;
        x_next        = x_reg;
        pop_data_next = pop_data_reg;
        pop_prio_next = pop_prio_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pop_data_next = '0;
                    pop_prio_next = '0;
                    if (!func)
                    begin
                        if (is_full)
                        begin
                            status_next = spq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            status_next = spq_pkg::STATUS_OK;
                            x_next      = new_entry;
                            stamp_next  = stamp_reg + 1'b1;
                            count_next  = count_reg + 1'b1;
                            idx_next    = count_reg[AW-1:0];
                            ra_a        = cnt_par[AW-1:0];
                            if (is_zero)
                            begin
                                we    = 1'b1;
                                waddr = '0;
                                wdata = new_entry;
                            end
                        end
                    end
                    else
                    begin
                        if (is_zero)
                        begin
                            status_next = spq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            status_next   = spq_pkg::STATUS_OK;
                            pop_data_next = head_reg[EW-1:KW];
                            pop_prio_next = head_reg[KW-1:SW];
                            count_next    = cnt_m1;
                            idx_next      = '0;
                            // fetch the last entry to refill the root
                            ra_a          = cnt_m1[AW-1:0];
                        end
                    end
                end
            end
            spq_pkg::ST_UP:
            begin
                we = 1'b1;
                if (x_above_p)
                begin
                    // move parent down into the hole, climb one level
                    wdata    = rd_a;
                    idx_next = par;
                    ra_a     = gpar;
                end
            end
            spq_pkg::ST_LAST:
            begin
                x_next = rd_a;
                if (!l_valid)
                begin
                    we    = 1'b1;
                    wdata = rd_a;
                end
            end
            spq_pkg::ST_DOWN:
            begin
                we = 1'b1;
                if (pick_l || pick_r)
                begin
                    // lift the winning child into the hole, descend
                    wdata    = pick_r ? rd_b : rd_a;
                    idx_next = child;
                    ra_a     = cl_w[AW-1:0];
                    ra_b     = cr_w[AW-1:0];
                end
            end
            spq_pkg::ST_WB:
            begin
                we = 1'b1;
            end
            spq_pkg::ST_DONE:
            begin
                we = 1'b0;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= spq_pkg::ST_IDLE;
            status_reg <= spq_pkg::STATUS_OK;
            count_reg  <= '0;
            stamp_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            stamp_reg  <= stamp_next;
        end
    end

    // root copy tracks every write to slot zero
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        x_reg        <= x_next;
        pop_data_reg <= pop_data_next;
        pop_prio_reg <= pop_prio_next;
        if (we && waddr == '0)
        begin
            head_reg <= wdata;
        end
    end

    assign stat.idle   = (state_reg == spq_pkg::ST_IDLE);
    assign stat.done   = (state_reg == spq_pkg::ST_DONE);
    assign stat.status = status_reg;
    assign pop_data    = pop_data_reg;
    assign pop_prio    = pop_prio_reg;
    assign head_data   = is_zero ? '0 : head_reg[EW-1:KW];
    assign head_prio   = is_zero ? '0 : head_reg[KW-1:SW];
    assign count       = count_reg;

endmodule

FILE: src/stable_priority_queue.sv
// Channel  Handshake             Fields
// -------  --------------------  --------------------------------------------------
// in       in_valid / in_ready   func, in_data, in_priority
// out      out_valid / out_ready out_data, out_priority, status, head_data,
//                                head_priority, entry_count, is_empty
//
// One item at a time; the dual-read entry memory moves one heap level per cycle: a
// push climbs in the up state, a pop fetches the last entry and sinks it in the down
// state or writes it to the root when one is left. Full, empty and single-entry
// cases go straight to done. Reset clears state, status, count, stamp and out_valid.
// in_ready is high in idle, also while a result waits in the output register;
// a stalled result holds the engine in its last state.
module stable_priority_queue #(
    parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [spq_pkg::OUT_DATA_W-1:0]     in_data,
    input  logic signed [spq_pkg::OUT_PRIO_W-1:0] in_priority,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [spq_pkg::OUT_DATA_W-1:0]     out_data,
    output logic signed [spq_pkg::OUT_PRIO_W-1:0] out_priority,
    output logic [1:0]                         status,
    output logic [spq_pkg::OUT_DATA_W-1:0]     head_data,
    output logic signed [spq_pkg::OUT_PRIO_W-1:0] head_priority,
    output logic [spq_pkg::OUT_COUNT_W-1:0]    entry_count,
    output logic                               is_empty
);

    localparam int ODW = spq_pkg::OUT_DATA_W;
    localparam int OPW = spq_pkg::OUT_PRIO_W;
    localparam int OCW = spq_pkg::OUT_COUNT_W;
    localparam int CW  = $clog2(CAPACITY + 1);

    spq_pkg::eng_stat_t    stat;
    logic                  start;
    logic                  res_take;
    logic [DATA_WIDTH+ODW-1:0] in_data_ext;
    logic [PRIO_WIDTH+OPW-1:0] in_prio_ext;
    logic [DATA_WIDTH-1:0] pop_data;
    logic [PRIO_WIDTH-1:0] pop_prio;
    logic [DATA_WIDTH-1:0] eng_head_data;
    logic [PRIO_WIDTH-1:0] eng_head_prio;
    logic [CW-1:0]         count;

    logic [DATA_WIDTH+ODW-1:0] pop_data_ext;
    logic [PRIO_WIDTH+OPW-1:0] pop_prio_ext;
    logic [DATA_WIDTH+ODW-1:0] head_data_ext;
    logic [PRIO_WIDTH+OPW-1:0] head_prio_ext;
    logic [CW+OCW-1:0]         count_ext;

    logic           out_valid_reg, out_valid_next;
    logic [ODW-1:0] out_data_reg;
    logic [OPW-1:0] out_prio_reg;
    logic [1:0]     status_reg;
    logic [ODW-1:0] head_data_reg;
    logic [OPW-1:0] head_prio_reg;
    logic [OCW-1:0] count_reg;
    logic           empty_reg;

    assign in_ready = stat.idle;
    assign start    = in_valid && stat.idle;
    assign res_take = stat.done && (!out_valid_reg || out_ready);

    assign in_data_ext = {{DATA_WIDTH{1'b0}}, in_data};
    assign in_prio_ext = {{PRIO_WIDTH{1'b0}}, in_priority};

    spq_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .new_data  (in_data_ext[DATA_WIDTH-1:0]),
        .new_prio  (in_prio_ext[PRIO_WIDTH-1:0]),
        .res_take  (res_take),
        .stat      (stat),
        .pop_data  (pop_data),
        .pop_prio  (pop_prio),
        .head_data (eng_head_data),
        .head_prio (eng_head_prio),
        .count     (count)
    );

    // widen payloads to the port widths, sign-extend priorities
    assign pop_data_ext  = {{ODW{1'b0}}, pop_data};
    assign head_data_ext = {{ODW{1'b0}}, eng_head_data};
    assign pop_prio_ext  = {{OPW{pop_prio[PRIO_WIDTH-1]}}, pop_prio};
    assign head_prio_ext = {{OPW{eng_head_prio[PRIO_WIDTH-1]}}, eng_head_prio};
    assign count_ext     = {{OCW{1'b0}}, count};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg  <= pop_data_ext[ODW-1:0];
            out_prio_reg  <= pop_prio_ext[OPW-1:0];
            status_reg    <= stat.status;
            head_data_reg <= head_data_ext[ODW-1:0];
            head_prio_reg <= head_prio_ext[OPW-1:0];
            count_reg     <= count_ext[OCW-1:0];
            empty_reg     <= (count == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_priority  = out_prio_reg;
    assign status        = status_reg;
    assign head_data     = head_data_reg;
    assign head_priority = head_prio_reg;
    assign entry_count   = count_reg;
    assign is_empty      = empty_reg;

endmodule
